### rtl/aesbc_pkg.sv
// Shared types, substitution tables and column arithmetic for the AES block cipher.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package aesbc_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_KEY_SIZE = 3'd0;
	localparam logic [2:0] REG_KEY_A    = 3'd1;
	localparam logic [2:0] REG_KEY_B    = 3'd2;
	localparam logic [2:0] REG_KEY_C    = 3'd3;
	localparam logic [2:0] REG_KEY_D    = 3'd4;

	// Key size codes.
	localparam logic [1:0] KSZ_128 = 2'd0;
	localparam logic [1:0] KSZ_192 = 2'd1;
	localparam logic [1:0] KSZ_256 = 2'd2;

	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_ADDKEY,
		ST_ROUND
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exp_init;
		logic exp_step;
		logic add_key;
		logic round_step;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic keys_ready;
		logic exp_last;
		logic round_last;
	} sts_t;

	localparam logic [7:0] FWD_BOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_BOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// Multiply by two in GF(2^8).
	function automatic logic [7:0] xt(input logic [7:0] b);
		xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// Substitute all four bytes of a word.
	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		sbox_word = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
	endfunction

	// MixColumns on one column, row 0 in the top byte.
	function automatic logic [31:0] mix_col(input logic [31:0] w);
		logic [7:0] a0, a1, a2, a3, all;
		a0 = w[31:24];
		a1 = w[23:16];
		a2 = w[15:8];
		a3 = w[7:0];
		all = a0 ^ a1 ^ a2 ^ a3;
		mix_col = {a0 ^ all ^ xt(a0 ^ a1), a1 ^ all ^ xt(a1 ^ a2),
			a2 ^ all ^ xt(a2 ^ a3), a3 ^ all ^ xt(a3 ^ a0)};
	endfunction

	// Products by 0x09, 0x0b, 0x0d and 0x0e of one byte.
	function automatic logic [31:0] inv_mults(input logic [7:0] a);
		logic [7:0] x2, x4, x8;
		x2 = xt(a);
		x4 = xt(x2);
		x8 = xt(x4);
		inv_mults = {x8 ^ a, x8 ^ x2 ^ a, x8 ^ x4 ^ a, x8 ^ x4 ^ x2};
	endfunction

	// InvMixColumns on one column.
	function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
		logic [31:0] m0, m1, m2, m3;
		m0 = inv_mults(w[31:24]);
		m1 = inv_mults(w[23:16]);
		m2 = inv_mults(w[15:8]);
		m3 = inv_mults(w[7:0]);
		// Fields of each product word: [31:24] x09, [23:16] x0b, [15:8] x0d, [7:0] x0e.
		inv_mix_col = {
			m0[7:0] ^ m1[23:16] ^ m2[15:8] ^ m3[31:24],
			m0[31:24] ^ m1[7:0] ^ m2[23:16] ^ m3[15:8],
			m0[15:8] ^ m1[31:24] ^ m2[7:0] ^ m3[23:16],
			m0[23:16] ^ m1[15:8] ^ m2[31:24] ^ m3[7:0]};
	endfunction

endpackage

`default_nettype wire

### rtl/aes_block_cipher_with_key_expansion_top.sv
// AES block cipher with key expansion: 128, 192 or 256-bit key, one round per cycle.
// A block is captured, the first round key is added and the rounds follow; the first block
// after a key register write waits first for word-serial key expansion. One block at a time;
// the last round also waits while an earlier result is still held in the output register.
// Reset (arst_n, asynchronous, active low) clears key registers and the key-ready flag.
`timescale 1ns / 1ps
`default_nettype none

module aes_block_cipher_with_key_expansion_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [63:0] cfg_data,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         opcode,
	input  wire  [63:0] text_high,
	input  wire  [63:0] text_low,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);
	import aesbc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	aesbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	aesbc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.text_high   (text_high),
		.text_low    (text_low),
		.result_high (result_high),
		.result_low  (result_low),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

`default_nettype wire

### rtl/aesbc_ctrl.sv
// Controller state machine of the AES block cipher.
// Depends on aesbc_pkg; drives the datapath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module aesbc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  aesbc_pkg::sts_t      sts,
	output aesbc_pkg::cmd_t      cmd
);
	import aesbc_pkg::*;

	state_t state_q, state_d;
	logic   out_free;

	assign out_free = !out_valid || out_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output register valid flag; the result waits here until its transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (sts.keys_ready) begin
						state_d = ST_ADDKEY;
					end else begin
						cmd.exp_init = 1'b1;
						state_d = ST_EXPAND;
					end
				end
			end
			ST_EXPAND: begin
				cmd.exp_step = 1'b1;
				if (sts.exp_last) begin
					state_d = ST_ADDKEY;
				end
			end
			ST_ADDKEY: begin
				cmd.add_key = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (sts.round_last) begin
					// The final round goes straight into the output register.
					if (out_free) begin
						cmd.out_load = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					cmd.round_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/aesbc_dp.sv
// Datapath of the AES block cipher: key registers, word-serial key expansion,
// round key stores, one-round-per-cycle cipher unit and output register. Uses aesbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aesbc_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire  [2:0]           cfg_index,
	input  wire  [63:0]          cfg_data,
	input  wire                  opcode,
	input  wire  [63:0]          text_high,
	input  wire  [63:0]          text_low,
	output logic [63:0]          result_high,
	output logic [63:0]          result_low,
	input  aesbc_pkg::cmd_t      cmd,
	output aesbc_pkg::sts_t      sts
);
	import aesbc_pkg::*;

	// Configuration registers.
	logic [1:0]   ksz_q;
	logic [63:0]  ka_q, kb_q, kc_q, kd_q;
	logic         keys_ready_q;

	// Key expansion state.
	logic [31:0]  win_q [8];
	logic [5:0]   cnt_q;
	logic [2:0]   kpos_q;
	logic [7:0]   rcon_q;
	logic [1:0]   sz_q;
	logic [3:0]   nr_q;
	logic [127:0] enc_q [15];
	logic [127:0] dec_q [15];

	// Cipher state.
	logic         opc_q;
	logic [127:0] text_q;
	logic [127:0] st_q;
	logic [3:0]   rnd_q;
	logic [127:0] res_q;

	logic [5:0]   nk;
	logic [63:0]  kw_sel;
	logic [31:0]  key_w, back_w, t_w, new_w, dec_w;
	logic [3:0]   wr_row, dec_row;
	logic [1:0]   wr_col;
	logic         rcon_adv;
	logic [127:0] rk, sh, mx, rnd_out;

	// Configuration writes; a write to the key size or a key register forces a new expansion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksz_q <= KSZ_128;
			ka_q <= '0;
			kb_q <= '0;
			kc_q <= '0;
			kd_q <= '0;
			keys_ready_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_SIZE: begin
						ksz_q <= cfg_data[1:0];
						keys_ready_q <= 1'b0;
					end
					REG_KEY_A: begin
						ka_q <= cfg_data;
						keys_ready_q <= 1'b0;
					end
					REG_KEY_B: begin
						kb_q <= cfg_data;
						keys_ready_q <= 1'b0;
					end
					REG_KEY_C: begin
						kc_q <= cfg_data;
						keys_ready_q <= 1'b0;
					end
					REG_KEY_D: begin
						kd_q <= cfg_data;
						keys_ready_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end else if (cmd.exp_step && sts.exp_last) begin
				keys_ready_q <= 1'b1;
			end
		end
	end

	// Next expanded word, from the key for the first Nk words, else from the window.
	always_comb begin
		nk = 6'd4 + {3'd0, sz_q, 1'b0};
		case (cnt_q[2:1])
			2'd0: kw_sel = ka_q;
			2'd1: kw_sel = kb_q;
			2'd2: kw_sel = kc_q;
			default: kw_sel = kd_q;
		endcase
		key_w = cnt_q[0] ? kw_sel[31:0] : kw_sel[63:32];
		case (sz_q)
			KSZ_128: back_w = win_q[3];
			KSZ_192: back_w = win_q[5];
			default: back_w = win_q[7];
		endcase
		rcon_adv = 1'b0;
		if (kpos_q == 3'd0) begin
			t_w = sbox_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'd0};
			rcon_adv = 1'b1;
		end else if (sz_q == KSZ_256 && kpos_q == 3'd4) begin
			t_w = sbox_word(win_q[0]);
		end else begin
			t_w = win_q[0];
		end
		new_w = (cnt_q < nk) ? key_w : (back_w ^ t_w);
		wr_row = cnt_q[5:2];
		wr_col = cnt_q[1:0];
		dec_row = nr_q - wr_row;
		dec_w = (wr_row == 4'd0 || wr_row == nr_q) ? new_w : inv_mix_col(new_w);
	end

	// Expansion registers: one word per cycle into both key stores.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			kpos_q <= '0;
			rcon_q <= 8'h01;
			sz_q <= KSZ_128;
			nr_q <= '0;
		end else if (cmd.exp_init) begin
			cnt_q <= '0;
			kpos_q <= '0;
			rcon_q <= 8'h01;
			sz_q <= (ksz_q == 2'd3) ? KSZ_256 : ksz_q;
			nr_q <= (ksz_q == 2'd3) ? 4'd14 : 4'd10 + {1'b0, ksz_q, 1'b0};
		end else if (cmd.exp_step) begin
			cnt_q <= cnt_q + 6'd1;
			kpos_q <= ({3'd0, kpos_q} == nk - 6'd1) ? 3'd0 : kpos_q + 3'd1;
			if (rcon_adv && cnt_q >= nk) begin
				rcon_q <= xt(rcon_q);
			end
		end
	end

	// Key window and round key stores.
	always_ff @(posedge clk) begin
		if (cmd.exp_step) begin
			for (int i = 7; i > 0; i--) begin
				win_q[i] <= win_q[i-1];
			end
			win_q[0] <= new_w;
			enc_q[wr_row][(3 - wr_col) * 32 +: 32] <= new_w;
			dec_q[dec_row][(3 - wr_col) * 32 +: 32] <= dec_w;
		end
	end

	// One cipher round: substitute and shift, mix unless final, add round key.
	always_comb begin
		rk = opc_q ? dec_q[rnd_q] : enc_q[rnd_q];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (opc_q == OP_DECRYPT) begin
					sh[127 - 8 * (4 * c + r) -: 8] =
						INV_BOX[st_q[127 - 8 * (4 * ((c + 4 - r) & 3) + r) -: 8]];
				end else begin
					sh[127 - 8 * (4 * c + r) -: 8] =
						FWD_BOX[st_q[127 - 8 * (4 * ((c + r) & 3) + r) -: 8]];
				end
			end
		end
		for (int c = 0; c < 4; c++) begin
			mx[127 - 32 * c -: 32] = opc_q ? inv_mix_col(sh[127 - 32 * c -: 32])
				: mix_col(sh[127 - 32 * c -: 32]);
		end
		rnd_out = (sts.round_last ? sh : mx) ^ rk;
	end

	// Round counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (cmd.capture) begin
			rnd_q <= '0;
		end else if (cmd.add_key || cmd.round_step) begin
			rnd_q <= rnd_q + 4'd1;
		end
	end

	// Block capture, cipher state and output payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			opc_q <= opcode;
			text_q <= {text_high, text_low};
		end
		if (cmd.add_key) begin
			st_q <= text_q ^ rk;
		end else if (cmd.round_step) begin
			st_q <= rnd_out;
		end
		if (cmd.out_load) begin
			res_q <= rnd_out;
		end
	end

	assign result_high = res_q[127:64];
	assign result_low = res_q[63:0];

	assign sts.keys_ready = keys_ready_q;
	assign sts.exp_last = (cnt_q == {nr_q, 2'b11});
	assign sts.round_last = (rnd_q == nr_q);

endmodule

`default_nettype wire

### rtl/aesbc_chk.sv
// Port-level checks of the AES block cipher top level, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module aesbc_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [63:0] result_high,
	input wire [63:0] result_low
);

	// A waiting result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before its transaction");

	// A waiting result keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(result_high) && $stable(result_low))
		else $error("result changed while stalled");

	// One block at a time: the input closes right after a transaction.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a block is in work");

	// No result can appear in the cycle after a block enters.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind aes_block_cipher_with_key_expansion_top aesbc_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.result_high (result_high),
	.result_low  (result_low)
);

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the AES block cipher with key expansion.
// Depends on rtl/aesbc_pkg.sv (register indexes, key size and opcode codes) and the top level.
`timescale 1ns / 1ps

module tb_top;
	import aesbc_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int SEGMENTS = 12;
	localparam int SEG_BLOCKS = 161;
	localparam logic [7:0] GF_POLY = 8'h1b;
	localparam logic [7:0] AFFINE_C = 8'h63;
	localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
	localparam logic [2:0] REG_BAD_LO = 3'd5;
	localparam logic [2:0] REG_BAD_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_ENCRYPT;
	logic [63:0] text_high = '0;
	logic [63:0] text_low = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [63:0] result_high;
	logic [63:0] result_low;

	aes_block_cipher_with_key_expansion_top dut (.*);

	always #6 clk = ~clk;

	// Predictor state: key registers, expanded schedules and substitution tables.
	logic [1:0] key_len;
	logic [63:0] key_regs [4];
	logic [31:0] enc_sched [60];
	logic [31:0] dec_sched [60];
	bit sched_valid;
	int unsigned num_rounds;
	logic [7:0] sbox [256];
	logic [7:0] rsbox [256];

	logic [127:0] cipher_q [$];
	int unsigned n_blocks, n_results, n_errors, n_keys, quiet;
	int unsigned send_idle_pct, recv_stall_pct, hold_left;

	function automatic logic [7:0] gf_dbl(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			if (b[k])
				acc ^= a;
			a = gf_dbl(a);
		end
		return acc;
	endfunction

	// Build the S-box and its inverse from the field inverse and the affine map.
	function automatic void build_boxes();
		logic [7:0] inv, s;
		for (int x = 0; x < 256; x++) begin
			inv = '0;
			for (int y = 1; y < 256; y++)
				if (gf_mul(x[7:0], y[7:0]) == 8'h01)
					inv = y[7:0];
			s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ AFFINE_C;
			sbox[x] = s;
			rsbox[s] = x[7:0];
		end
	endfunction

	function automatic logic [31:0] col_mix(input logic [31:0] w, input bit inverse);
		logic [7:0] a [4];
		logic [7:0] o [4];
		for (int r = 0; r < 4; r++)
			a[r] = w[31 - 8 * r -: 8];
		for (int r = 0; r < 4; r++) begin
			if (inverse)
				o[r] = gf_mul(a[r], 8'h0e) ^ gf_mul(a[(r + 1) % 4], 8'h0b)
					^ gf_mul(a[(r + 2) % 4], 8'h0d) ^ gf_mul(a[(r + 3) % 4], 8'h09);
			else
				o[r] = gf_mul(a[r], 8'h02) ^ gf_mul(a[(r + 1) % 4], 8'h03)
					^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
		end
		return {o[0], o[1], o[2], o[3]};
	endfunction

	function automatic logic [31:0] sub_bytes4(input logic [31:0] w);
		return {sbox[w[31:24]], sbox[w[23:16]], sbox[w[15:8]], sbox[w[7:0]]};
	endfunction

	// Expand the key and derive the equivalent inverse cipher schedule.
	function automatic void expand_schedule();
		int unsigned sz, nk, total;
		logic [31:0] t;
		logic [7:0] rcon;
		sz = (key_len > 2) ? 2 : key_len;
		nk = 4 + 2 * sz;
		num_rounds = nk + 6;
		total = 4 * (num_rounds + 1);
		rcon = 8'h01;
		for (int i = 0; i < nk; i++)
			enc_sched[i] = i[0] ? key_regs[i / 2][31:0] : key_regs[i / 2][63:32];
		for (int i = nk; i < total; i++) begin
			t = enc_sched[i - 1];
			if (i % nk == 0) begin
				t = sub_bytes4({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
				rcon = gf_dbl(rcon);
			end else if (nk == 8 && i % nk == 4) begin
				t = sub_bytes4(t);
			end
			enc_sched[i] = enc_sched[i - nk] ^ t;
		end
		for (int r = 0; r <= num_rounds; r++)
			for (int c = 0; c < 4; c++) begin
				t = enc_sched[4 * (num_rounds - r) + c];
				dec_sched[4 * r + c] = (r != 0 && r != num_rounds) ? col_mix(t, 1'b1) : t;
			end
		sched_valid = 1'b1;
	endfunction

	// Register write as the block sees it; out-of-range indexes change nothing.
	function automatic void apply_reg(input logic [2:0] idx, input logic [63:0] data);
		if (idx == REG_KEY_SIZE)
			key_len = data[1:0];
		else if (idx <= REG_KEY_D)
			key_regs[idx - REG_KEY_A] = data;
		else
			return;
		sched_valid = 1'b0;
	endfunction

	// One block through the cipher; s[4c+r] is row r of column c.
	function automatic logic [127:0] cipher_block(input logic op, input logic [63:0] hi,
		input logic [63:0] lo);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [31:0] rk, col;
		logic [127:0] res;
		bit dec;
		dec = (op == OP_DECRYPT);
		if (!sched_valid)
			expand_schedule();
		for (int i = 0; i < 8; i++) begin
			s[i] = hi[63 - 8 * i -: 8];
			s[8 + i] = lo[63 - 8 * i -: 8];
		end
		for (int r = 0; r <= num_rounds; r++) begin
			if (r != 0) begin
				for (int c = 0; c < 4; c++)
					for (int w = 0; w < 4; w++)
						if (dec)
							t[4 * ((c + w) % 4) + w] = rsbox[s[4 * c + w]];
						else
							t[4 * c + w] = sbox[s[4 * ((c + w) % 4) + w]];
				s = t;
				if (r != num_rounds)
					for (int c = 0; c < 4; c++) begin
						col = col_mix({s[4 * c], s[4 * c + 1], s[4 * c + 2], s[4 * c + 3]}, dec);
						for (int w = 0; w < 4; w++)
							s[4 * c + w] = col[31 - 8 * w -: 8];
					end
			end
			for (int c = 0; c < 4; c++) begin
				rk = dec ? dec_sched[4 * r + c] : enc_sched[4 * r + c];
				for (int w = 0; w < 4; w++)
					s[4 * c + w] ^= rk[31 - 8 * w -: 8];
			end
		end
		for (int i = 0; i < 16; i++)
			res[127 - 8 * i -: 8] = s[i];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		n_errors++;
		$display("[%0t] %s mismatch: got %h, expected %h", $realtime, what, got, want);
	endtask

	// Result side: random stalls, plus a long hold-off when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check each result transaction at the falling edge, where all signals are settled.
	always @(negedge clk) begin
		logic [127:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results++;
				if (cipher_q.size() == 0) begin
					report_mismatch("unexpected result", result_high, '0);
				end else begin
					want = cipher_q.pop_front();
					if (result_high !== want[127:64])
						report_mismatch("result_high", result_high, want[127:64]);
					if (result_low !== want[63:0])
						report_mismatch("result_low", result_low, want[63:0]);
				end
			end
			// Watchdog on cycles without any transaction.
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Timeout after %0d quiet cycles", quiet);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Offer one block and wait for its transaction; called at a rising edge.
	task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo,
		input bit typed, input logic [127:0] typed_want);
		logic [127:0] pred;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		opcode <= op;
		text_high <= hi;
		text_low <= lo;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		pred = cipher_block(op, hi, lo);
		cipher_q.push_back(typed ? typed_want : pred);
		n_blocks++;
	endtask

	// Stop offering and wait until every expected result has come.
	task automatic drain();
		in_valid <= 1'b0;
		while (cipher_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic end_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
		n_keys++;
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Directed plan: register writes and blocks, with known answers typed where obvious.
	typedef struct packed {
		bit is_cfg;
		logic [2:0] idx;
		logic [63:0] data;
		logic op;
		logic [63:0] hi;
		logic [63:0] lo;
		bit typed;
		logic [127:0] want;
	} plan_row_t;

	localparam logic [63:0] PT_HI = 64'h0011223344556677;
	localparam logic [63:0] PT_LO = 64'h8899aabbccddeeff;
	localparam logic [127:0] CT_128 = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
	localparam logic [127:0] CT_192 = 128'hdda97ca4864cdfe06eaf70a0ec0d7191;
	localparam logic [127:0] CT_256 = 128'h8ea2b7ca516745bfeafc49904b496089;

	localparam int PLAN_LEN = 28;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// Key of zeros after reset.
		'{0, REG_KEY_SIZE, 64'h0, OP_ENCRYPT, 64'h0, 64'h0, 1,
			128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
		'{0, REG_KEY_SIZE, 64'h0, OP_DECRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{0, REG_KEY_SIZE, 64'h0, OP_ENCRYPT, ONES, ONES, 0, 128'h0},
		'{0, REG_KEY_SIZE, 64'h0, OP_DECRYPT, ONES, ONES, 0, 128'h0},
		// 128-bit standard key.
		'{1, REG_KEY_A, 64'h0001020304050607, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{1, REG_KEY_B, 64'h08090a0b0c0d0e0f, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{0, REG_KEY_SIZE, 64'h0, OP_ENCRYPT, PT_HI, PT_LO, 1, CT_128},
		'{0, REG_KEY_SIZE, 64'h0, OP_DECRYPT, CT_128[127:64], CT_128[63:0], 1, {PT_HI, PT_LO}},
		// 192-bit standard key.
		'{1, REG_KEY_C, 64'h1011121314151617, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{1, REG_KEY_SIZE, {62'h0, KSZ_192}, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{0, REG_KEY_SIZE, 64'h0, OP_ENCRYPT, PT_HI, PT_LO, 1, CT_192},
		'{0, REG_KEY_SIZE, 64'h0, OP_DECRYPT, CT_192[127:64], CT_192[63:0], 1, {PT_HI, PT_LO}},
		// 256-bit standard key.
		'{1, REG_KEY_D, 64'h18191a1b1c1d1e1f, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{1, REG_KEY_SIZE, {62'h0, KSZ_256}, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{0, REG_KEY_SIZE, 64'h0, OP_ENCRYPT, PT_HI, PT_LO, 1, CT_256},
		'{0, REG_KEY_SIZE, 64'h0, OP_DECRYPT, CT_256[127:64], CT_256[63:0], 1, {PT_HI, PT_LO}},
		// Key size three saturates to 256 bits.
		'{1, REG_KEY_SIZE, ONES, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{0, REG_KEY_SIZE, 64'h0, OP_ENCRYPT, PT_HI, PT_LO, 1, CT_256},
		// Writes to indexes past the last register are ignored.
		'{1, REG_BAD_LO, ONES, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{1, REG_BAD_HI, ONES, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{0, REG_KEY_SIZE, 64'h0, OP_ENCRYPT, PT_HI, PT_LO, 1, CT_256},
		// Back to 128 bits with the upper key words left set: they are unused.
		'{1, REG_KEY_SIZE, {62'h0, KSZ_128}, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{0, REG_KEY_SIZE, 64'h0, OP_ENCRYPT, PT_HI, PT_LO, 1, CT_128},
		// Key words A and B of all ones, 256 bits.
		'{1, REG_KEY_A, ONES, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{1, REG_KEY_B, ONES, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{1, REG_KEY_SIZE, {62'h0, KSZ_256}, OP_ENCRYPT, 64'h0, 64'h0, 0, 128'h0},
		'{0, REG_KEY_SIZE, 64'h0, OP_ENCRYPT, ONES, ONES, 0, 128'h0},
		'{0, REG_KEY_SIZE, 64'h0, OP_DECRYPT, 64'h0, ONES, 0, 128'h0}
	};

	initial begin
		logic [63:0] hi, lo;
		bit in_writes;
		key_len = KSZ_128;
		foreach (key_regs[i])
			key_regs[i] = '0;
		sched_valid = 1'b0;
		num_rounds = 0;
		n_blocks = 0;
		n_results = 0;
		n_errors = 0;
		n_keys = 0;
		quiet = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		build_boxes();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan; a group of register writes starts once the block is idle.
		in_writes = 0;
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].is_cfg) begin
				if (!in_writes)
					drain();
				in_writes = 1;
				write_reg(PLAN[i].idx, PLAN[i].data);
			end else begin
				if (in_writes)
					end_writes();
				in_writes = 0;
				send_block(PLAN[i].op, PLAN[i].hi, PLAN[i].lo, PLAN[i].typed, PLAN[i].want);
			end
		end

		// Random segments, each under a fresh key and one of the idling patterns.
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			case (seg % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 54; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 54; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			for (int r = REG_KEY_A; r <= REG_KEY_D; r++)
				if ($urandom_range(3) != 0)
					write_reg(r[2:0], rand_word());
			if ($urandom_range(3) == 0)
				write_reg(3'($urandom_range(REG_BAD_HI, REG_BAD_LO)), rand_word());
			write_reg(REG_KEY_SIZE, {$urandom, $urandom});
			end_writes();
			// Long receiver hold-off while blocks keep coming, so the input backs up.
			if (seg == 1)
				hold_left = 400;
			for (int k = 0; k < SEG_BLOCKS; k++) begin
				hi = ($urandom_range(19) == 0) ? ($urandom_range(1) ? ONES : '0) : rand_word();
				lo = ($urandom_range(19) == 0) ? ($urandom_range(1) ? ONES : '0) : rand_word();
				send_block(1'($urandom_range(1)), hi, lo, 0, '0);
				// Sender pause until every expected result is in.
				if (seg == 2 && k == SEG_BLOCKS / 2)
					drain();
			end
		end

		drain();
		repeat (80) @(posedge clk);
		$display("Sent %0d blocks under %0d key settings, checked %0d results.",
			n_blocks, n_keys + 1, n_results);
		$display("Both directions, all key sizes, ignored register writes and stalls covered.");
		if (n_errors == 0 && cipher_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
